// ===== src/brsm_pkg.sv =====
// Shared types and constants for the banked ROM/SRAM mapper with kanji port.
// No dependencies; used by every module in src.
package brsm_pkg;

	localparam int WINDOW_COUNT = 6;
	localparam int BANK_REG_COUNT = 6;
	localparam int WIN_IDX_W = 3;

	localparam logic [1:0] OP_MEM_RD = 2'd0;
	localparam logic [1:0] OP_MEM_WR = 2'd1;
	localparam logic [1:0] OP_IO_RD = 2'd2;
	localparam logic [1:0] OP_IO_WR = 2'd3;

	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_ROM_RD = 3'd1;
	localparam logic [2:0] TGT_SRAM_RD = 3'd2;
	localparam logic [2:0] TGT_SRAM_WR = 3'd3;
	localparam logic [2:0] TGT_READBACK = 3'd4;

	localparam logic [15:0] BANK_REG_ADDR [BANK_REG_COUNT] = '{
		16'h6000, 16'h6400, 16'h6800, 16'h6C00, 16'h7000, 16'h7800
	};
	localparam logic [15:0] CONTROL_ADDR = 16'h7FF9;
	localparam logic [15:0] READBACK_BASE = 16'h7FF0;
	localparam logic [15:0] READBACK_LAST = 16'h7FF5;
	localparam logic [WIN_IDX_W-1:0] READBACK_WIN = 3'd3;
	localparam int READBACK_EN_BIT = 2;
	localparam logic [6:0] SRAM_BANK_HI = 7'h40;
	localparam logic [7:0] KANJI_LOAD_LO = 8'hD8;
	localparam logic [7:0] KANJI_LOAD_HI = 8'hD9;

	typedef logic [WINDOW_COUNT-1:0][7:0] bank_vec_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [20:0] phys_address;
		logic [7:0]  read_data;
	} rsp_t;

	typedef struct packed {
		logic                 bank_we;
		logic [WIN_IDX_W-1:0] bank_idx;
		logic [7:0]           bank_data;
		logic                 ctrl_we;
		logic [7:0]           ctrl_data;
		logic                 latch_we;
		logic [16:0]          latch_data;
	} upd_t;

endpackage

// ===== src/brsm_state.sv =====
// Bank numbers, control byte and kanji latch of the mapper.
// Depends on brsm_pkg.
module brsm_state (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  brsm_pkg::upd_t    upd,
	output brsm_pkg::bank_vec_t banks,
	output logic [7:0]        ctrl,
	output logic [16:0]       latch
);

	brsm_pkg::bank_vec_t banks_q;
	logic [7:0]          ctrl_q;
	logic [16:0]         latch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banks_q <= '0;
			ctrl_q  <= '0;
			latch_q <= '0;
		end else if (commit) begin
			for (int i = 0; i < brsm_pkg::WINDOW_COUNT; i++) begin
				if (upd.bank_we && upd.bank_idx == brsm_pkg::WIN_IDX_W'(i)) begin
					banks_q[i] <= upd.bank_data;
				end
			end
			if (upd.ctrl_we) begin
				ctrl_q <= upd.ctrl_data;
			end
			if (upd.latch_we) begin
				latch_q <= upd.latch_data;
			end
		end
	end

	assign banks = banks_q;
	assign ctrl  = ctrl_q;
	assign latch = latch_q;

endmodule

// ===== src/brsm_decode.sv =====
// Access decode: window mapping, register writes, readback and kanji port.
// Depends on brsm_pkg.
module brsm_decode (
	input  brsm_pkg::req_t      req,
	input  brsm_pkg::bank_vec_t banks,
	input  logic [7:0]          ctrl,
	input  logic [16:0]         latch,
	output brsm_pkg::rsp_t      rsp,
	output brsm_pkg::upd_t      upd
);

	function automatic logic [7:0] bank_of(brsm_pkg::bank_vec_t b,
			logic [brsm_pkg::WIN_IDX_W-1:0] idx);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < brsm_pkg::WINDOW_COUNT; i++) begin
			if (idx == brsm_pkg::WIN_IDX_W'(i)) begin
				r = b[i];
			end
		end
		return r;
	endfunction

	logic [brsm_pkg::WIN_IDX_W-1:0] win;
	logic        win_ok;
	logic [7:0]  bank;
	logic        is_sram;
	logic [20:0] rom_addr;
	logic [20:0] sram_addr;
	logic        reg_hit;
	logic [brsm_pkg::WIN_IDX_W-1:0] reg_idx;
	logic        readback;
	logic [16:0] kanji_l;
	logic [7:0]  port;

	always_comb begin
		win       = req.address[15:13];
		win_ok    = {1'b0, win} < (brsm_pkg::WIN_IDX_W + 1)'(brsm_pkg::WINDOW_COUNT);
		bank      = bank_of(banks, win);
		is_sram   = bank[7:1] == brsm_pkg::SRAM_BANK_HI;
		rom_addr  = {bank, req.address[12:0]};
		sram_addr = {7'd0, bank[0], req.address[12:0]};
		port      = req.address[7:0];
		kanji_l   = {latch[4], latch[3], latch[16:5], latch[2:0]};

		reg_hit = 1'b0;
		reg_idx = '0;
		for (int i = 0; i < brsm_pkg::BANK_REG_COUNT; i++) begin
			if (req.address == brsm_pkg::BANK_REG_ADDR[i]) begin
				reg_hit = 1'b1;
				reg_idx = brsm_pkg::WIN_IDX_W'(i);
			end
		end

		readback = win_ok && win == brsm_pkg::READBACK_WIN
			&& ctrl[brsm_pkg::READBACK_EN_BIT]
			&& req.address >= brsm_pkg::READBACK_BASE
			&& req.address <= brsm_pkg::READBACK_LAST;

		rsp = '0;
		upd = '0;
		upd.bank_idx   = reg_idx;
		upd.bank_data  = req.write_data;
		upd.ctrl_data  = req.write_data;

		unique case (req.operation)
			brsm_pkg::OP_MEM_RD: begin
				if (readback) begin
					rsp.target    = brsm_pkg::TGT_READBACK;
					rsp.read_data = bank_of(banks, req.address[2:0]);
				end else if (win_ok && is_sram) begin
					rsp.target       = brsm_pkg::TGT_SRAM_RD;
					rsp.phys_address = sram_addr;
				end else if (win_ok) begin
					rsp.target       = brsm_pkg::TGT_ROM_RD;
					rsp.phys_address = rom_addr;
				end
			end
			brsm_pkg::OP_MEM_WR: begin
				if (reg_hit) begin
					upd.bank_we = 1'b1;
				end else if (req.address == brsm_pkg::CONTROL_ADDR) begin
					upd.ctrl_we = 1'b1;
				end else if (win_ok && is_sram) begin
					rsp.target       = brsm_pkg::TGT_SRAM_WR;
					rsp.phys_address = sram_addr;
				end
			end
			brsm_pkg::OP_IO_RD: begin
				if (port == brsm_pkg::KANJI_LOAD_HI) begin
					rsp.target       = brsm_pkg::TGT_ROM_RD;
					rsp.phys_address = {2'b10, latch[4:3] == 2'b00, 1'b0, kanji_l};
					upd.latch_we     = 1'b1;
					upd.latch_data   = {latch[16:5], latch[4:0] + 5'd1};
				end
			end
			brsm_pkg::OP_IO_WR: begin
				if (port == brsm_pkg::KANJI_LOAD_LO) begin
					upd.latch_we   = 1'b1;
					upd.latch_data = {latch[16:11], req.write_data[5:0], 5'd0};
				end else if (port == brsm_pkg::KANJI_LOAD_HI) begin
					upd.latch_we   = 1'b1;
					upd.latch_data = {req.write_data[5:0], latch[10:5], 5'd0};
				end
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

// ===== src/banked_rom_sram_mapper_with_kanji_port.sv =====
// Top level of the banked ROM/SRAM mapper with kanji port.
// Depends on brsm_pkg, brsm_state and brsm_decode.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | brsm_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready | brsm_pkg::rsp_t
//
// One access per cycle sustained while rsp_ready is high; results are registered.
// Decode sits between the request register and the result register, and
// bank, control and latch state change when an access moves into the result register.
// Reset clears all bank numbers, the control byte and the kanji latch.
// A stalled result holds the request register; req_ready drops only when both are full.
module banked_rom_sram_mapper_with_kanji_port (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  brsm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output brsm_pkg::rsp_t rsp
);

	logic                valid_s1;
	brsm_pkg::req_t      req_s1;
	logic                rsp_valid_q;
	brsm_pkg::rsp_t      rsp_q;
	logic                advance;
	brsm_pkg::bank_vec_t banks;
	logic [7:0]          ctrl;
	logic [16:0]         latch;
	brsm_pkg::rsp_t      rsp_d;
	brsm_pkg::upd_t      upd;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	brsm_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.upd    (upd),
		.banks  (banks),
		.ctrl   (ctrl),
		.latch  (latch)
	);

	brsm_decode u_decode (
		.req   (req_s1),
		.banks (banks),
		.ctrl  (ctrl),
		.latch (latch),
		.rsp   (rsp_d),
		.upd   (upd)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_readback_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.target == brsm_pkg::TGT_READBACK
		|-> ctrl[brsm_pkg::READBACK_EN_BIT])
		else $error("readback result while readback disabled");

	a_sram_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.target == brsm_pkg::TGT_SRAM_RD
			|| rsp_q.target == brsm_pkg::TGT_SRAM_WR)
		|-> rsp_q.phys_address[20:14] == 7'd0)
		else $error("SRAM address out of range");

	a_data_only_readback: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.target != brsm_pkg::TGT_READBACK
		|-> rsp_q.read_data == 8'd0)
		else $error("read data on non-readback result");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(ctrl) && $stable(latch) && $stable(banks))
		else $error("state changed without a result transfer");
`endif

endmodule

// ===== bench/tb_banked_rom_sram_mapper_with_kanji_port.sv =====
// Testbench for banked_rom_sram_mapper_with_kanji_port: directed and random bus accesses,
// each decode checked in order against a scoreboard that tracks banks, control and latch.
// Depends on brsm_pkg and the mapper RTL in src.
module tb_banked_rom_sram_mapper_with_kanji_port;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1450;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;
	localparam logic [20:0] KANJI_ROM_BASE = 21'h100000;
	localparam logic [15:0] WINDOW_TOP = 16'hBFFF;

	class decode_scoreboard;
		logic [7:0] banks [brsm_pkg::BANK_REG_COUNT];
		logic [7:0] ctrl;
		logic [16:0] latch;
		brsm_pkg::rsp_t expected_decodes [$];
		int bad;

		function new();
			foreach (banks[i])
				banks[i] = 8'd0;
			ctrl = 8'd0;
			latch = 17'd0;
			bad = 0;
		endfunction

		function brsm_pkg::rsp_t decode_access(brsm_pkg::req_t a);
			brsm_pkg::rsp_t r;
			logic [2:0] win;
			logic [18:0] kaddr;
			bit hit;
			r = '0;
			r.target = brsm_pkg::TGT_NONE;
			win = a.address[15:13];
			hit = 1'b0;
			case (a.operation)
				brsm_pkg::OP_MEM_WR: begin
					for (int i = 0; i < brsm_pkg::BANK_REG_COUNT; i++)
						if (a.address == brsm_pkg::BANK_REG_ADDR[i]) begin
							banks[i] = a.write_data;
							hit = 1'b1;
						end
					if (a.address == brsm_pkg::CONTROL_ADDR) begin
						ctrl = a.write_data;
						hit = 1'b1;
					end
					if (!hit && win < brsm_pkg::WINDOW_COUNT) begin
						if (banks[win][7:1] == brsm_pkg::SRAM_BANK_HI) begin
							r.target = brsm_pkg::TGT_SRAM_WR;
							r.phys_address = {7'd0, banks[win][0], a.address[12:0]};
						end
					end
				end
				brsm_pkg::OP_MEM_RD: begin
					if (win < brsm_pkg::WINDOW_COUNT) begin
						if (win == brsm_pkg::READBACK_WIN &&
								ctrl[brsm_pkg::READBACK_EN_BIT] &&
								a.address >= brsm_pkg::READBACK_BASE &&
								a.address <= brsm_pkg::READBACK_LAST) begin
							r.target = brsm_pkg::TGT_READBACK;
							r.read_data = banks[int'(a.address - brsm_pkg::READBACK_BASE)];
						end else if (banks[win][7:1] == brsm_pkg::SRAM_BANK_HI) begin
							r.target = brsm_pkg::TGT_SRAM_RD;
							r.phys_address = {7'd0, banks[win][0], a.address[12:0]};
						end else begin
							r.target = brsm_pkg::TGT_ROM_RD;
							r.phys_address = {banks[win], a.address[12:0]};
						end
					end
				end
				brsm_pkg::OP_IO_RD: begin
					if (a.address[7:0] == brsm_pkg::KANJI_LOAD_HI) begin
						kaddr = {2'b00, latch[4], latch[3], latch[16:5], latch[2:0]};
						if (kaddr[16:15] == 2'b00)
							kaddr[18] = 1'b1;
						r.target = brsm_pkg::TGT_ROM_RD;
						r.phys_address = KANJI_ROM_BASE | {2'b00, kaddr};
						latch[4:0] = latch[4:0] + 5'd1;
					end
				end
				brsm_pkg::OP_IO_WR: begin
					if (a.address[7:0] == brsm_pkg::KANJI_LOAD_LO)
						latch = {latch[16:11], a.write_data[5:0], 5'd0};
					else if (a.address[7:0] == brsm_pkg::KANJI_LOAD_HI)
						latch = {a.write_data[5:0], latch[10:5], 5'd0};
				end
			endcase
			return r;
		endfunction

		function void note_access(brsm_pkg::req_t a);
			expected_decodes.push_back(decode_access(a));
		endfunction

		function void check_decode(brsm_pkg::rsp_t got);
			brsm_pkg::rsp_t want;
			if (expected_decodes.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("unexpected result: target %0d phys %h data %h",
						got.target, got.phys_address, got.read_data);
				return;
			end
			want = expected_decodes.pop_front();
			if (got.target !== want.target || got.phys_address !== want.phys_address ||
					got.read_data !== want.read_data) begin
				bad++;
				if (bad <= 10)
					$display({"mismatch at %0t: target exp %0d got %0d, ",
						"phys exp %h got %h, data exp %h got %h"},
						$realtime, want.target, got.target, want.phys_address,
						got.phys_address, want.read_data, got.read_data);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	brsm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	brsm_pkg::rsp_t rsp;

	decode_scoreboard tracker = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int cycle_count = 0;

	banked_rom_sram_mapper_with_kanji_port dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				tracker.note_access(req);
			if (rsp_valid && rsp_ready)
				tracker.check_decode(rsp);
		end
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic brsm_pkg::req_t make_access(logic [1:0] op, logic [15:0] addr,
			logic [7:0] data);
		brsm_pkg::req_t a;
		a.operation = op;
		a.address = addr;
		a.write_data = data;
		return a;
	endfunction

	function automatic logic [7:0] pick_bank();
		if ($urandom_range(1))
			return 8'h80 | 8'($urandom_range(1));
		return 8'($urandom_range(255));
	endfunction

	task automatic send_access(input brsm_pkg::req_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		items_sent++;
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_decodes.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_access(make_access(brsm_pkg::OP_MEM_RD, 16'h0000, 8'h00));
		send_access(make_access(brsm_pkg::OP_MEM_RD, 16'hFFFF, 8'hFF));
		send_access(make_access(brsm_pkg::OP_MEM_RD, WINDOW_TOP, 8'h00));
		send_access(make_access(brsm_pkg::OP_MEM_WR, brsm_pkg::BANK_REG_ADDR[0], 8'h80));
		send_access(make_access(brsm_pkg::OP_MEM_WR, brsm_pkg::BANK_REG_ADDR[1], 8'h81));
		send_access(make_access(brsm_pkg::OP_MEM_WR, brsm_pkg::BANK_REG_ADDR[2], 8'hFF));
		send_access(make_access(brsm_pkg::OP_MEM_WR, brsm_pkg::BANK_REG_ADDR[3], 8'h82));
		send_access(make_access(brsm_pkg::OP_MEM_WR, brsm_pkg::BANK_REG_ADDR[4], 8'h7F));
		send_access(make_access(brsm_pkg::OP_MEM_WR, brsm_pkg::BANK_REG_ADDR[5], 8'h80));
		send_access(make_access(brsm_pkg::OP_MEM_WR, 16'h1234, 8'hAA));
		send_access(make_access(brsm_pkg::OP_MEM_RD, 16'h3FFF, 8'h00));
		send_access(make_access(brsm_pkg::OP_MEM_WR, 16'h4000, 8'h55));
		send_access(make_access(brsm_pkg::OP_MEM_WR, 16'hA000, 8'hFF));
		send_access(make_access(brsm_pkg::OP_MEM_RD, brsm_pkg::READBACK_BASE, 8'h00));
		send_access(make_access(brsm_pkg::OP_MEM_WR, brsm_pkg::CONTROL_ADDR, 8'h04));
		send_access(make_access(brsm_pkg::OP_MEM_RD, brsm_pkg::READBACK_BASE, 8'h00));
		send_access(make_access(brsm_pkg::OP_MEM_RD, brsm_pkg::READBACK_LAST, 8'h00));
		send_access(make_access(brsm_pkg::OP_MEM_RD, brsm_pkg::READBACK_LAST + 16'd1,
			8'h00));
		send_access(make_access(brsm_pkg::OP_MEM_WR, 16'hC000, 8'h12));
		send_access(make_access(brsm_pkg::OP_IO_WR, {8'h00, brsm_pkg::KANJI_LOAD_LO},
			8'hFF));
		send_access(make_access(brsm_pkg::OP_IO_WR, {8'hFF, brsm_pkg::KANJI_LOAD_HI},
			8'h3F));
		send_access(make_access(brsm_pkg::OP_IO_RD, {8'h00, brsm_pkg::KANJI_LOAD_HI},
			8'h00));
		send_access(make_access(brsm_pkg::OP_IO_WR, {8'h00, brsm_pkg::KANJI_LOAD_HI},
			8'hC0));
		send_access(make_access(brsm_pkg::OP_IO_RD, {8'h12, brsm_pkg::KANJI_LOAD_HI},
			8'h00));
		send_access(make_access(brsm_pkg::OP_IO_RD, {8'h00, brsm_pkg::KANJI_LOAD_LO},
			8'h00));
	endtask

	task automatic run_random(input int count);
		int stop_at;
		int pick;
		int reads;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 18)
				send_access(make_access(brsm_pkg::OP_MEM_WR,
					brsm_pkg::BANK_REG_ADDR[$urandom_range(brsm_pkg::BANK_REG_COUNT - 1)],
					pick_bank()));
			else if (pick < 23)
				send_access(make_access(brsm_pkg::OP_MEM_WR, brsm_pkg::CONTROL_ADDR,
					8'($urandom_range(255))));
			else if (pick < 50)
				send_access(make_access(brsm_pkg::OP_MEM_RD, 16'($urandom_range(WINDOW_TOP)),
					8'($urandom_range(255))));
			else if (pick < 56)
				send_access(make_access(brsm_pkg::OP_MEM_RD,
					brsm_pkg::READBACK_BASE + 16'($urandom_range(7)),
					8'($urandom_range(255))));
			else if (pick < 70)
				send_access(make_access(brsm_pkg::OP_MEM_WR, 16'($urandom_range(WINDOW_TOP)),
					8'($urandom_range(255))));
			else if (pick < 85) begin
				send_access(make_access(brsm_pkg::OP_IO_WR,
					{8'($urandom_range(255)), brsm_pkg::KANJI_LOAD_LO},
					8'($urandom_range(255))));
				send_access(make_access(brsm_pkg::OP_IO_WR,
					{8'($urandom_range(255)), brsm_pkg::KANJI_LOAD_HI},
					8'($urandom_range(255))));
				reads = $urandom_range(40, 1);
				repeat (reads)
					send_access(make_access(brsm_pkg::OP_IO_RD,
						{8'($urandom_range(255)), brsm_pkg::KANJI_LOAD_HI},
						8'($urandom_range(255))));
			end else
				send_access(make_access(2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
					8'($urandom_range(255))));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 8;
		stall_pct = 49;
		run_directed();
		wait_for_results();
		run_random(RANDOM_ITEMS / 3);
		send_idle_pct = 49;
		stall_pct = 8;
		run_random(RANDOM_ITEMS / 3);
		wait_for_results();
		send_idle_pct = 0;
		stall_pct = 0;
		run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.bad == 0 && tracker.expected_decodes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/brsm_pkg.sv
src/brsm_state.sv
src/brsm_decode.sv
src/banked_rom_sram_mapper_with_kanji_port.sv
bench/tb_banked_rom_sram_mapper_with_kanji_port.sv
